/* sv/sfh_pkg.sv */
`default_nettype none
package sfh_pkg;

	// Request handed from the byte stage to the finishing pipeline
	typedef struct packed {
		logic [63:0] hash;
		logic [23:0] pend;
		logic [1:0]  cnt;
	} fin_req_t;

	// Sign-extend one tail byte to the state width
	function automatic logic [63:0] sext8(input logic [7:0] b);
		return {{56{b[7]}}, b};
	endfunction

	// Mix one complete group of four bytes into the running hash
	function automatic logic [63:0] mix_group(input logic [63:0] rh,
			input logic [15:0] lo16, input logic [15:0] hi16);
		logic [63:0] h;
		logic [31:0] t;
		h = rh + {48'd0, lo16};
		t = {5'd0, hi16, 11'd0} ^ h[31:0];
		h = (h << 16) ^ {32'd0, t};
		return h + (h >> 11);
	endfunction

	// Fold in a tail of three, two or one bytes
	function automatic logic [63:0] tail_mix(input logic [63:0] rh,
			input logic [23:0] p, input logic [1:0] cnt);
		logic [63:0] h;
		h = rh;
		unique case (cnt)
			2'd3: begin
				h = h + {48'd0, p[15:0]};
				h = h ^ (h << 16);
				h = h ^ (sext8(p[23:16]) << 18);
				h = h + (h >> 11);
			end
			2'd2: begin
				h = h + {48'd0, p[15:0]};
				h = h ^ (h << 11);
				h = h + (h >> 17);
			end
			2'd1: begin
				h = h + sext8(p[7:0]);
				h = h ^ (h << 10);
				h = h + (h >> 1);
			end
			default: begin
				h = rh;
			end
		endcase
		return h;
	endfunction

	// Avalanche, split in three steps of one wide add each
	function automatic logic [63:0] aval_a(input logic [63:0] x);
		logic [63:0] h;
		h = x ^ (x << 3);
		return h + (h >> 5);
	endfunction

	function automatic logic [63:0] aval_b(input logic [63:0] x);
		logic [63:0] h;
		h = x ^ (x << 4);
		return h + (h >> 17);
	endfunction

	function automatic logic [63:0] aval_c(input logic [63:0] x);
		logic [63:0] h;
		h = x ^ (x << 25);
		return h + (h >> 6);
	endfunction

endpackage
`default_nettype wire

/* sv/sfh_finish.sv */
`default_nettype none
module sfh_finish
	import sfh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire fin_req_t    req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      hash_out
);

	logic        v_s2, v_s3, v_s4, v_s5;
	fin_req_t    req_s2;
	logic [63:0] h_s3, h_s4, h_s5;
	logic        rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_o;

	// Each stage moves on when the next one is empty or moving
	assign rdy_o  = !out_valid || !out_stall;
	assign rdy_s5 = !v_s5 || rdy_o;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign req_ready = rdy_s2;

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= req_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_o)  out_valid <= v_s5;
		end
	end

	// Tail mix, then the avalanche in three steps
	always_ff @(posedge clk) begin
		if (rdy_s2 && req_valid) req_s2 <= req;
		if (rdy_s3 && v_s2) h_s3 <= tail_mix(req_s2.hash, req_s2.pend, req_s2.cnt);
		if (rdy_s4 && v_s3) h_s4 <= aval_a(h_s3);
		if (rdy_s5 && v_s4) h_s5 <= aval_b(h_s4);
		if (rdy_o && v_s5)  hash_out <= aval_c(h_s5);
	end

endmodule
`default_nettype wire

/* sv/superfasthash_byte_stream_unit.sv */
// Streaming 64-bit string hash, one byte per request.
// Input channel: in_valid / in_stall with byte_in, no_data and last. A request
// is taken at a clock edge with in_valid high and in_stall low. no_data marks
// a request without a byte (used to close an empty string); last closes the
// string and causes exactly one result.
// Output channel: out_valid / out_stall with hash_out, one request per string.
// Throughput: one input request per cycle while in_stall is low. Groups of
// four bytes are mixed into the running hash combinationally from the input
// register, so the byte stage never waits on the hash state.
// Path to hash_out from the edge that took the last request: byte-stage
// register, finishing input register, tail mix, two avalanche stages, then the
// last avalanche step straight into the output register.
// Reset (arst_n low) empties every stage and clears the running hash and the
// pending tail bytes; no result is pending afterwards.
// When the receiver stalls, the finishing pipeline fills up; in_stall rises
// only when a last request cannot move into it, while requests that are not
// last keep being taken.
`default_nettype none
module superfasthash_byte_stream_unit
	import sfh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_in,
	input  wire logic        no_data,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      hash_out
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        nodata_s1;
	logic        last_s1;
	logic [63:0] hash_q;
	logic [23:0] pend_q;
	logic [1:0]  cnt_q;
	logic [63:0] hash_nx;
	logic [23:0] pend_nx;
	logic [1:0]  cnt_nx;
	logic        fin_ready;
	logic        fire_s1;
	fin_req_t    fin_req;

	// The byte stage drops non-last requests at once
	assign fire_s1  = v_s1 && (!last_s1 || fin_ready);
	assign in_stall = v_s1 && !fire_s1;

	// Hold the input request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1   <= byte_in;
			nodata_s1 <= no_data;
			last_s1   <= last;
		end
	end

	// Collect the byte, or mix a full group
	always_comb begin
		hash_nx = hash_q;
		pend_nx = pend_q;
		cnt_nx  = cnt_q;
		if (!nodata_s1) begin
			unique case (cnt_q)
				2'd3: begin
					hash_nx = mix_group(hash_q, pend_q[15:0], {byte_s1, pend_q[23:16]});
					pend_nx = 24'd0;
					cnt_nx  = 2'd0;
				end
				2'd2: begin
					pend_nx = {byte_s1, pend_q[15:0]};
					cnt_nx  = 2'd3;
				end
				2'd1: begin
					pend_nx = {8'd0, byte_s1, pend_q[7:0]};
					cnt_nx  = 2'd2;
				end
				default: begin
					pend_nx = {16'd0, byte_s1};
					cnt_nx  = 2'd1;
				end
			endcase
		end
	end

	assign fin_req.hash = hash_nx;
	assign fin_req.pend = pend_nx;
	assign fin_req.cnt  = cnt_nx;

	// Update the string state; clear it when the string closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= 64'd0;
			pend_q <= 24'd0;
			cnt_q  <= 2'd0;
		end else if (fire_s1) begin
			if (last_s1) begin
				hash_q <= 64'd0;
				pend_q <= 24'd0;
				cnt_q  <= 2'd0;
			end else begin
				hash_q <= hash_nx;
				pend_q <= pend_nx;
				cnt_q  <= cnt_nx;
			end
		end
	end

	sfh_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (v_s1 && last_s1),
		.req_ready (fin_ready),
		.req       (fin_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hash_out  (hash_out)
	);

endmodule
`default_nettype wire
